>>> rtl/core/stip_pkg.sv
// Package for the string to integer parser: phase codes, trailing kinds,
// status codes, widths and the digit decode function. No dependencies.
`timescale 1ns / 1ps
package stip_pkg;
    localparam int COUNT_WIDTH = 24;
    localparam int VALUE_WIDTH = 64;

    typedef enum logic [4:0] {
        PH_SIGN   = 5'b00001,
        PH_ZERO   = 5'b00010,
        PH_ZEROX  = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_TRAIL  = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        TK_NONE   = 2'd0,
        TK_SPACES = 2'd1,
        TK_CHARS  = 2'd2
    } trail_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_BIG   = 3'd1;
    localparam logic [2:0] ST_NEG_UNS   = 3'd2;
    localparam logic [2:0] ST_NO_DIGITS = 3'd3;
    localparam logic [2:0] ST_CHARS_W   = 3'd4;
    localparam logic [2:0] ST_SPACES_W  = 3'd5;
    localparam logic [2:0] ST_CHARS_E   = 3'd6;
    localparam logic [2:0] ST_SPACES_E  = 3'd7;

    localparam logic [2:0] REG_BASE    = 3'd0;
    localparam logic [2:0] REG_MAXLEN  = 3'd1;
    localparam logic [2:0] REG_SIGNED  = 3'd2;
    localparam logic [2:0] REG_WIDTH   = 3'd3;
    localparam logic [2:0] REG_STRICT  = 3'd4;

    // Digit value of an ASCII byte; 255 if not alphanumeric.
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] r;
        r = 8'd255;
        if (c >= "0" && c <= "9") r = c - 8'd48;
        else if (c >= "a" && c <= "z") r = c - 8'd87;
        else if (c >= "A" && c <= "Z") r = c - 8'd55;
        return r;
    endfunction

    // Overflow pre-test shift by base; 64 means never.
    function automatic logic [6:0] shift_by_base(input logic [5:0] b);
        logic [6:0] r;
        if (b < 6'd2) r = 7'd64;
        else if (b < 6'd4) r = 7'd63;
        else if (b < 6'd8) r = 7'd62;
        else if (b < 6'd16) r = 7'd61;
        else if (b < 6'd32) r = 7'd60;
        else r = 7'd59;
        return r;
    endfunction
endpackage

>>> rtl/core/string_to_integer_parser.sv
// Top level of the streaming string to integer parser.
// Depends on stip_pkg and stip_finish.
`timescale 1ns / 1ps
// Usage:
//  s_axis carries one ASCII byte per transaction (tdata[7:0] = character).
//  A NUL byte ends the string and produces one m_axis transaction; other
//  bytes produce none. Configuration is written through cfg_we/cfg_index/
//  cfg_data while the block is idle; base and max_length are captured at
//  the first byte of each string, the others are used at the NUL.
//  A byte is folded into the parser state in the cycle it is accepted; the
//  result of a NUL is written to the output register when the NUL is accepted.
//  Throughput is one byte per cycle while no result waits in a full output
//  slot, set by the single 64-bit multiply-add of the digit step.
//  The output register is a single slot: s_axis_tready stays high while it
//  is empty or being drained, so a stalled receiver only blocks the next
//  byte when a result is still waiting.
//  Reset (rst_n low, asynchronous) clears the parser state, the output valid
//  flag and the configuration to base auto, no limit, unsigned,
//  64-bit, not strict.
//  m_axis tdata: value [63:0], status [66:64], stop_offset [90:67], zero fill.
module string_to_integer_parser
    import stip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // character [7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // value [63:0], status [66:64], stop_offset [90:67]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    // configuration
    logic [5:0]             base_reg;
    logic [COUNT_WIDTH-1:0] max_length_reg;
    logic                   signed_mode_reg;
    logic [1:0]             result_width_reg;
    logic                   strict_mode_reg;

    // parser state
    phase_t                 phase_reg, phase_next;
    logic                   negative_reg, negative_next;
    logic [5:0]             base_in_use_reg, base_in_use_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   overflowed_reg, overflowed_next;
    logic                   digit_seen_reg, digit_seen_next;
    logic [COUNT_WIDTH-1:0] remaining_reg, remaining_next;
    logic [COUNT_WIDTH-1:0] position_reg, position_next;
    logic [COUNT_WIDTH-1:0] stop_reg, stop_next;
    trail_t                 trail_reg, trail_next;
    logic                   started_reg, started_next;
    logic                   unlimited_reg, unlimited_next;

    // output slot
    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic [2:0]             out_status_reg;
    logic [COUNT_WIDTH-1:0] out_stop_reg;

    logic                   accept;
    logic [7:0]             c;
    logic [7:0]             dv;
    logic                   emit;

    // snapshot state going into the NUL
    logic [VALUE_WIDTH-1:0] f_acc;
    logic                   f_neg, f_ovf, f_seen;
    trail_t                 f_trail;
    logic [COUNT_WIDTH-1:0] f_stop;
    logic [VALUE_WIDTH-1:0] fin_value;
    logic [2:0]             fin_status;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign c = s_axis_tdata;
    assign dv = digit_value(c);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {5'd0, out_stop_reg, out_status_reg, out_value_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            max_length_reg <= '0;
            signed_mode_reg <= 1'b0;
            result_width_reg <= 2'd3;
            strict_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE:   base_reg <= cfg_data[5:0];
                REG_MAXLEN: max_length_reg <= cfg_data[COUNT_WIDTH-1:0];
                REG_SIGNED: signed_mode_reg <= cfg_data[0];
                REG_WIDTH:  result_width_reg <= cfg_data[1:0];
                REG_STRICT: strict_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Per-byte step; mirrors the sign/zero/prefix/digit/trailing flow.
    always_comb
    begin
        logic                   bud;
        logic                   go_digit;
        logic                   go_trail;
        logic [7:0]             tc;
        logic [VALUE_WIDTH-1:0] prod;
        logic [VALUE_WIDTH-1:0] sum;
        logic [6:0]             sh;
        logic                   do_take;
        logic                   do_spend;
        logic                   second_trail;

        phase_next = phase_reg;
        negative_next = negative_reg;
        base_in_use_next = base_in_use_reg;
        acc_next = acc_reg;
        overflowed_next = overflowed_reg;
        digit_seen_next = digit_seen_reg;
        remaining_next = remaining_reg;
        position_next = position_reg;
        stop_next = stop_reg;
        trail_next = trail_reg;
        unlimited_next = unlimited_reg;
        started_next = 1'b1;
        go_digit = 1'b0;
        go_trail = 1'b0;
        tc = c;
        do_take = 1'b0;
        do_spend = 1'b0;
        second_trail = 1'b0;
        emit = 1'b0;
        prod = '0;
        sum = '0;
        sh = '0;

        if (!started_reg)
        begin
            base_in_use_next = (base_reg < 6'd36) ? base_reg : 6'd0;
            remaining_next = max_length_reg;
            unlimited_next = (max_length_reg == '0);
        end
        bud = unlimited_next || remaining_next != '0;

        unique case (phase_reg)
            PH_SIGN:
            begin
                if (bud && c == "+")
                begin
                    negative_next = 1'b0;
                    do_take = 1'b1;
                end
                else if (bud && c == "-")
                begin
                    negative_next = !negative_reg;
                    do_take = 1'b1;
                end
                else if (c == "0" && bud &&
                         (base_in_use_next == 6'd0 || base_in_use_next == 6'd16))
                begin
                    do_take = 1'b1;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    if (base_in_use_next == 6'd0) base_in_use_next = 6'd10;
                    phase_next = PH_DIGITS;
                    go_digit = 1'b1;
                end
            end
            PH_ZERO:
            begin
                if ((c == "x" || c == "X") && bud)
                    phase_next = PH_ZEROX;
                else
                begin
                    if (base_in_use_next == 6'd0)
                        base_in_use_next = (dv < 8'd8) ? 6'd8 : 6'd10;
                    digit_seen_next = 1'b1;
                    phase_next = PH_DIGITS;
                    go_digit = 1'b1;
                end
            end
            PH_ZEROX:
            begin
                if (dv < 8'd16)
                begin
                    base_in_use_next = 6'd16;
                    phase_next = PH_DIGITS;
                    go_digit = 1'b1;
                    do_take = 1'b1;
                end
                else
                begin
                    if (base_in_use_next == 6'd0) base_in_use_next = 6'd10;
                    digit_seen_next = 1'b1;
                    stop_next = position_reg;
                    phase_next = PH_TRAIL;
                    // 'x' is a trailing char; then the current byte
                    if (bud) trail_next = TK_CHARS;
                    second_trail = 1'b1;
                end
            end
            PH_DIGITS: go_digit = 1'b1;
            default:   go_trail = 1'b1;
        endcase

        // The prefix take in PH_ZEROX happens before the digit check.
        if (do_take && go_digit)
        begin
            if (!unlimited_next && remaining_next != '0)
                remaining_next = remaining_next - 1'b1;
            if (position_next != '1) position_next = position_next + 1'b1;
            do_take = 1'b0;
        end
        bud = unlimited_next || remaining_next != '0;

        if (go_digit)
        begin
            if (!bud || c == 8'd0 || base_in_use_next >= 6'd36 ||
                dv >= {2'b00, base_in_use_next})
            begin
                stop_next = position_next;
                phase_next = PH_TRAIL;
                go_trail = 1'b1;
            end
            else
            begin
                prod = acc_reg * {58'd0, base_in_use_next};
                sum = prod + {56'd0, dv};
                sh = shift_by_base(base_in_use_next);
                acc_next = sum;
                if (acc_reg > sum || (sh < 7'd64 && (acc_reg >> sh) != '0))
                    overflowed_next = 1'b1;
                digit_seen_next = 1'b1;
                do_take = 1'b1;
            end
        end

        if (do_take)
        begin
            if (!unlimited_next && remaining_next != '0)
                remaining_next = remaining_next - 1'b1;
            if (position_next != '1) position_next = position_next + 1'b1;
        end

        if (go_trail || second_trail)
        begin
            if (tc == 8'd0)
                emit = 1'b1;
            else if (trail_next != TK_CHARS && bud)
            begin
                if (tc == " " || tc == 8'd9)
                begin
                    trail_next = TK_SPACES;
                    do_spend = 1'b1;
                end
                else
                    trail_next = TK_CHARS;
            end
        end
        if (do_spend && !unlimited_next && remaining_next != '0)
            remaining_next = remaining_next - 1'b1;

        f_acc = acc_next;
        f_neg = negative_next;
        f_ovf = overflowed_next;
        f_seen = digit_seen_next;
        f_trail = trail_next;
        f_stop = stop_next;

        if (emit)
        begin
            phase_next = PH_SIGN;
            negative_next = 1'b0;
            base_in_use_next = '0;
            acc_next = '0;
            overflowed_next = 1'b0;
            digit_seen_next = 1'b0;
            position_next = '0;
            stop_next = '0;
            trail_next = TK_NONE;
            started_next = 1'b0;
        end
    end

    stip_finish u_finish (
        .acc           (f_acc),
        .negative      (f_neg),
        .overflowed    (f_ovf),
        .digit_seen    (f_seen),
        .trailing_kind (f_trail),
        .signed_mode   (signed_mode_reg),
        .result_width  (result_width_reg),
        .strict_mode   (strict_mode_reg),
        .value         (fin_value),
        .status        (fin_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIGN;
            negative_reg <= 1'b0;
            base_in_use_reg <= '0;
            acc_reg <= '0;
            overflowed_reg <= 1'b0;
            digit_seen_reg <= 1'b0;
            remaining_reg <= '0;
            position_reg <= '0;
            stop_reg <= '0;
            trail_reg <= TK_NONE;
            started_reg <= 1'b0;
            unlimited_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                negative_reg <= negative_next;
                base_in_use_reg <= base_in_use_next;
                acc_reg <= acc_next;
                overflowed_reg <= overflowed_next;
                digit_seen_reg <= digit_seen_next;
                remaining_reg <= remaining_next;
                position_reg <= position_next;
                stop_reg <= stop_next;
                trail_reg <= trail_next;
                started_reg <= started_next;
                unlimited_reg <= unlimited_next;
            end
            if (accept && emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_value_reg <= fin_value;
            out_status_reg <= fin_status;
            out_stop_reg <= f_stop;
        end
    end
endmodule

>>> rtl/core/stip_finish.sv
// Result formation at the terminating NUL: sign, status, narrowing.
// Depends on stip_pkg.
`timescale 1ns / 1ps
module stip_finish
    import stip_pkg::*;
(
    input  logic [VALUE_WIDTH-1:0] acc,
    input  logic                   negative,
    input  logic                   overflowed,
    input  logic                   digit_seen,
    input  trail_t                 trailing_kind,
    input  logic                   signed_mode,
    input  logic [1:0]             result_width,
    input  logic                   strict_mode,
    output logic [VALUE_WIDTH-1:0] value,
    output logic [2:0]             status
);
    logic [VALUE_WIDTH-1:0] neg_v;
    logic [VALUE_WIDTH-1:0] v;
    logic [VALUE_WIDTH-1:0] sx;
    logic [VALUE_WIDTH-1:0] zx;
    logic [2:0]             rc;

    always_comb
    begin
        neg_v = '0 - acc;
        rc = overflowed ? ST_TOO_BIG : ST_OK;
        v = acc;
        if (!signed_mode)
        begin
            if (negative)
            begin
                if (rc == ST_OK) rc = ST_NEG_UNS;
                v = neg_v;
            end
            if (!digit_seen) rc = ST_NO_DIGITS;
        end
        else if (!acc[VALUE_WIDTH-1])
        begin
            if (!digit_seen) rc = ST_NO_DIGITS;
            v = negative ? neg_v : acc;
        end
        else if (negative && acc == {1'b1, {(VALUE_WIDTH-1){1'b0}}})
        begin
            v = acc;
        end
        else
        begin
            rc = ST_TOO_BIG;
            v = negative ? neg_v : acc;
        end
        if (rc == ST_OK && trailing_kind != TK_NONE)
            rc = (trailing_kind == TK_CHARS) ? ST_CHARS_W : ST_SPACES_W;
        if (strict_mode)
        begin
            if (rc == ST_CHARS_W || rc == ST_SPACES_W) rc = rc + 3'd2;
            else if ((rc == ST_TOO_BIG || rc == ST_NEG_UNS) && trailing_kind != TK_NONE)
                rc = (trailing_kind == TK_CHARS) ? ST_CHARS_E : ST_SPACES_E;
        end
        unique case (result_width)
            2'd0:
            begin
                sx = {{56{v[7]}}, v[7:0]};
                zx = {56'd0, v[7:0]};
            end
            2'd1:
            begin
                sx = {{48{v[15]}}, v[15:0]};
                zx = {48'd0, v[15:0]};
            end
            2'd2:
            begin
                sx = {{32{v[31]}}, v[31:0]};
                zx = {32'd0, v[31:0]};
            end
            default:
            begin
                sx = v;
                zx = v;
            end
        endcase
        if (rc != ST_NO_DIGITS && rc != ST_CHARS_E && rc != ST_SPACES_E)
        begin
            if ((signed_mode ? sx : zx) != v) rc = ST_TOO_BIG;
        end
        value = signed_mode ? sx : zx;
        status = rc;
    end
endmodule

>>> test/stip_checker.sv
// Checker for the string to integer parser: watches the byte and result streams,
// predicts each result in its own model and compares field by field.
// Depends on stip_pkg.
`timescale 1ns / 1ps
module stip_checker
    import stip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [95:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    typedef struct packed {
        logic [23:0] stop_offset;
        logic [2:0]  status;
        logic [63:0] value;
    } parse_result_t;

    parse_result_t expected_results[$];

    // configuration copy
    logic [5:0]  cfg_base;
    logic [23:0] cfg_maxlen;
    logic        cfg_signed, cfg_strict;
    logic [1:0]  cfg_width;

    // parser state copy
    phase_t      ph;
    logic        neg, ovf, seen, started, unlim;
    logic [5:0]  base_cur;
    logic [63:0] acc;
    logic [23:0] left, pos, stop_pos;
    trail_t      tk;

    function automatic logic [7:0] char_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - 8'd48;
        if (c >= "a" && c <= "z") return c - 8'd87;
        if (c >= "A" && c <= "Z") return c - 8'd55;
        return 8'd255;
    endfunction

    function automatic int guard_shift(logic [5:0] b);
        if (b < 2) return 64;
        if (b < 4) return 63;
        if (b < 8) return 62;
        if (b < 16) return 61;
        if (b < 32) return 60;
        return 59;
    endfunction

    function automatic logic [63:0] sign_ext(logic [63:0] v, int bits);
        logic [63:0] m, s;
        m = (64'd1 << bits) - 64'd1;
        s = 64'd1 << (bits - 1);
        return ((v & m) ^ s) - s;
    endfunction

    function automatic logic has_budget();
        return unlim || left != 0;
    endfunction

    task automatic consume_budget();
        if (!unlim && left != 0) left = left - 24'd1;
    endtask

    task automatic consume_byte();
        consume_budget();
        if (pos != 24'hffffff) pos = pos + 24'd1;
    endtask

    task automatic clear_string();
        ph = PH_SIGN; neg = 0; base_cur = 0; acc = 0; ovf = 0; seen = 0;
        pos = 0; stop_pos = 0; tk = TK_NONE; started = 0;
    endtask

    task automatic emit_result();
        logic [63:0] v, negv, mask;
        logic [2:0] rc;
        int bits;
        logic fits;
        rc = ovf ? ST_TOO_BIG : ST_OK;
        bits = 8 << cfg_width;
        negv = 64'd0 - acc;
        v = acc;
        if (!cfg_signed) begin
            if (neg) begin
                if (rc == ST_OK) rc = ST_NEG_UNS;
                v = negv;
            end
            if (!seen) rc = ST_NO_DIGITS;
        end else if (!acc[63]) begin
            if (!seen) rc = ST_NO_DIGITS;
            v = neg ? negv : acc;
        end else if (neg && acc == 64'h8000_0000_0000_0000) begin
            v = acc;
        end else begin
            rc = ST_TOO_BIG;
            v = neg ? negv : acc;
        end
        if (rc == ST_OK && tk != TK_NONE) rc = (tk == TK_CHARS) ? ST_CHARS_W : ST_SPACES_W;
        if (cfg_strict) begin
            if (rc == ST_CHARS_W) rc = ST_CHARS_E;
            else if (rc == ST_SPACES_W) rc = ST_SPACES_E;
            else if ((rc == ST_TOO_BIG || rc == ST_NEG_UNS) && tk != TK_NONE)
                rc = (tk == TK_CHARS) ? ST_CHARS_E : ST_SPACES_E;
        end
        if (bits < 64) begin
            mask = (64'd1 << bits) - 64'd1;
            if (rc != ST_NO_DIGITS && rc != ST_CHARS_E && rc != ST_SPACES_E) begin
                fits = cfg_signed ? (sign_ext(v, bits) == v) : ((v & ~mask) == 0);
                if (!fits) rc = ST_TOO_BIG;
            end
            v = cfg_signed ? sign_ext(v, bits) : (v & mask);
        end
        expected_results.push_back('{stop_offset: stop_pos, status: rc, value: v});
        clear_string();
    endtask

    task automatic trailing_byte(logic [7:0] c);
        if (c == 8'd0) emit_result();
        else if (tk != TK_CHARS && has_budget()) begin
            if (c == " " || c == 8'd9) begin
                tk = TK_SPACES;
                consume_budget();
            end else tk = TK_CHARS;
        end
    endtask

    task automatic digit_byte(logic [7:0] c);
        logic [7:0] d;
        logic [63:0] prev;
        int sh;
        d = char_digit(c);
        if (!has_budget() || c == 8'd0 || base_cur >= 36 || d >= base_cur) begin
            stop_pos = pos;
            ph = PH_TRAIL;
            trailing_byte(c);
        end else begin
            prev = acc;
            acc = acc * base_cur + d;
            sh = guard_shift(base_cur);
            if (prev > acc || (sh < 64 && (prev >> sh) != 0)) ovf = 1;
            seen = 1;
            consume_byte();
        end
    endtask

    task automatic parse_byte(logic [7:0] c);
        if (!started) begin
            started = 1;
            base_cur = (cfg_base < 36) ? cfg_base : 6'd0;
            left = cfg_maxlen;
            unlim = (cfg_maxlen == 0);
        end
        case (ph)
            PH_SIGN: begin
                if (has_budget() && c == "+") begin
                    neg = 0;
                    consume_byte();
                end else if (has_budget() && c == "-") begin
                    neg = ~neg;
                    consume_byte();
                end else if (c == "0" && (base_cur == 0 || base_cur == 16) && has_budget()) begin
                    consume_byte();
                    ph = PH_ZERO;
                end else begin
                    if (base_cur == 0) base_cur = 10;
                    ph = PH_DIGITS;
                    digit_byte(c);
                end
            end
            PH_ZERO: begin
                if ((c == "x" || c == "X") && has_budget()) ph = PH_ZEROX;
                else begin
                    if (base_cur == 0) base_cur = (char_digit(c) < 8) ? 6'd8 : 6'd10;
                    seen = 1;
                    ph = PH_DIGITS;
                    digit_byte(c);
                end
            end
            PH_ZEROX: begin
                if (char_digit(c) < 16) begin
                    base_cur = 16;
                    consume_byte();
                    ph = PH_DIGITS;
                    digit_byte(c);
                end else begin
                    // prefix rejected: the x itself becomes trailing
                    if (base_cur == 0) base_cur = 10;
                    seen = 1;
                    stop_pos = pos;
                    ph = PH_TRAIL;
                    trailing_byte("x");
                    trailing_byte(c);
                end
            end
            PH_DIGITS: digit_byte(c);
            default: trailing_byte(c);
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin
        parse_result_t got, want;
        int errs;
        errs = 0;
        if (!rst_n) begin
            cfg_base = 0; cfg_maxlen = 0; cfg_signed = 0; cfg_width = 2'd3; cfg_strict = 0;
            clear_string();
            left = 0; unlim = 0;
            expected_results.delete();
            fail_count <= 0;
            result_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_BASE:   cfg_base = cfg_data[5:0];
                    REG_MAXLEN: cfg_maxlen = cfg_data;
                    REG_SIGNED: cfg_signed = cfg_data[0];
                    REG_WIDTH:  cfg_width = cfg_data[1:0];
                    REG_STRICT: cfg_strict = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[90:0];
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction %h", m_axis_tdata);
                    errs = errs + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value) begin
                        $error("value: expected %h actual %h", want.value, got.value);
                        errs = errs + 1;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, got.status);
                        errs = errs + 1;
                    end
                    if (got.stop_offset !== want.stop_offset) begin
                        $error("stop_offset: expected %0d actual %0d",
                               want.stop_offset, got.stop_offset);
                        errs = errs + 1;
                    end
                end
                fail_count <= fail_count + errs;
            end
            if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata);
        end
        pending_count = expected_results.size();
    end
endmodule

>>> test/tb.sv
// Testbench top for string_to_integer_parser: drives strings byte by byte,
// writes configuration between phases and reports the verdict.
// Depends on stip_pkg, stip_checker and the RTL.
`timescale 1ns / 1ps
module tb;
    import stip_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [95:0] m_axis_tdata;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = REG_BASE;
    logic [23:0] cfg_data = 0;

    int fail_count, pending_count, result_count;
    int cycle_count = 0;
    int bytes_sent = 0;
    int burst_left = 0;
    logic [7:0] text_bytes[$];

    always #2 clk = ~clk;

    string_to_integer_parser u_top (.*);

    stip_checker u_check (.*);

    // Generous limit: each byte may wait out a long gap plus a long stall.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver stall pattern: stretches of always-ready, others random.
    always @(posedge clk) begin
        if (cycle_count[9:8] == 2'd0) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // Sender: bursts of transactions with random gaps; tvalid held through a burst.
    task automatic send_byte(logic [7:0] c);
        if (burst_left == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(0, 5)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= c;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
        send_byte(8'd0);
    endtask

    // Idle the block: drop tvalid at once, drain expected results, then let the
    // output register settle.
    task automatic drain();
        s_axis_tvalid <= 0;
        burst_left = 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_digit(int b);
        int d;
        d = $urandom_range(0, (b < 2) ? 9 : b - 1);
        if (d < 10) return 8'd48 + d[7:0];
        return ($urandom_range(0, 1) ? 8'd87 : 8'd55) + d[7:0];
    endfunction

    // Mostly well formed numbers, with noise and odd tails.
    task automatic random_string(int b);
        int n;
        text_bytes.delete();
        n = $urandom_range(0, 3);
        repeat (n) text_bytes.push_back($urandom_range(0, 2) ? "-" : "+");
        case ($urandom_range(0, 5))
            0: begin text_bytes.push_back("0"); text_bytes.push_back("x"); end
            1: text_bytes.push_back("0");
            default: ;
        endcase
        n = $urandom_range(0, 14);
        repeat (n) text_bytes.push_back(pick_digit(b));
        case ($urandom_range(0, 5))
            0: repeat ($urandom_range(1, 3)) text_bytes.push_back(" ");
            1: text_bytes.push_back(8'd9);
            2: repeat ($urandom_range(1, 3)) text_bytes.push_back(8'($urandom_range(1, 255)));
            default: ;
        endcase
        foreach (text_bytes[i]) send_byte(text_bytes[i]);
        send_byte(8'd0);
    endtask

    initial begin
        int b;
        repeat (6) @(posedge clk);
        rst_n <= 1;

        // directed part, reset configuration: auto base, 64-bit unsigned
        send_text("");
        send_text("18446744073709551615");
        send_text("18446744073709551616");
        send_text("-+-0x1fF");
        send_text("0x");
        send_text("0xg");
        send_text("017");
        send_text("-5");
        send_text("12 ");
        send_text("12ab");
        send_byte(8'hff); send_byte(8'd0);
        send_byte(8'h80); send_byte(8'd0);
        drain();
        write_reg(REG_SIGNED, 24'd1);
        write_reg(REG_STRICT, 24'd1);
        write_reg(REG_WIDTH, 24'd0);
        send_text("-128");
        send_text("128");
        send_text("-9223372036854775808");
        send_text("9223372036854775808");
        send_text("7\t");
        send_text("-x");
        drain();
        write_reg(REG_BASE, 24'd1);
        write_reg(REG_MAXLEN, 24'd3);
        send_text("0001");
        drain();
        write_reg(REG_BASE, 24'd63);
        write_reg(REG_MAXLEN, 24'hffffff);
        send_text("0x12");
        drain();
        write_reg(REG_BASE, 24'd16);
        write_reg(REG_MAXLEN, 24'd2);
        send_text("0xAB");
        send_text("0x");
        drain();
        write_reg(REG_BASE, 24'd35);
        write_reg(REG_MAXLEN, 24'd0);
        write_reg(REG_WIDTH, 24'd3);
        send_text("ZzYy");
        drain();

        // random phases over varied settings
        for (int phase_no = 0; phase_no < 12; phase_no++) begin
            b = (phase_no % 3 == 0) ? 0 : $urandom_range(0, 63);
            write_reg(REG_BASE, 24'(b));
            write_reg(REG_MAXLEN, 24'($urandom_range(0, 2) ? 0 : $urandom_range(1, 20)));
            write_reg(REG_SIGNED, 24'($urandom_range(0, 1)));
            write_reg(REG_WIDTH, 24'($urandom_range(0, 3)));
            write_reg(REG_STRICT, 24'($urandom_range(0, 1)));
            for (int k = 0; k < 3; k++) random_string((b == 0 || b > 35) ? 16 : b);
            // a pure noise string in every phase
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(1, 255)));
            send_byte(8'd0);
            drain();
        end

        repeat (20) @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Parsed %0d strings from %0d bytes across signs, prefixes, bases,",
                 result_count, bytes_sent);
        $display("limits, widths, signed and strict settings.");
        if (fail_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
